FILE: sv/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, defaults and constant tables for the CORDIC sine/cosine unit.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int ITERATIONS_DEFAULT   = 16;
  localparam int ANGLE_WIDTH_DEFAULT  = 16;
  localparam int RESULT_WIDTH_DEFAULT = 16;

  // The constants below carry 30 fraction bits.
  localparam int TABLE_FRAC = 30;
  localparam int TABLE_DEPTH = 24;

  localparam longint ATAN_Q30 [TABLE_DEPTH] = '{
    64'sd843314857, 64'sd497837830, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
    64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
    64'sd1024,      64'sd512,       64'sd256,       64'sd128
  };

  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint GAIN_Q30 = 64'sd652032875;

  // Control that travels alongside each rotating vector.
  typedef struct packed {
    logic valid;
    logic folded;
  } ctrl_t;

  // Rescales a positive 30-fraction-bit constant to frac <= 30 fraction bits,
  // rounding half up; frac > 30 gives v back. Evaluated at elaboration only.
  function automatic longint rescale(input longint v, input int frac);
    int     s;
    longint r;
    s = TABLE_FRAC - frac;
    if (s <= 0) begin
      r = v;
    end else begin
      r = (v + (64'sd1 <<< (s - 1))) >>> s;
    end
    return r;
  endfunction

endpackage

FILE: sv/csc_if.sv
// ----------------------------------------------------------------------------
// csc_if
// Valid/ready channels for angle beats and sine/cosine result beats.
// ----------------------------------------------------------------------------
interface csc_angle_if #(
  parameter int ANGLE_WIDTH = csc_pkg::ANGLE_WIDTH_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface csc_result_if #(
  parameter int RESULT_WIDTH = csc_pkg::RESULT_WIDTH_DEFAULT
);
  logic                           valid;
  logic                           ready;
  logic signed [RESULT_WIDTH-1:0] sine;
  logic signed [RESULT_WIDTH-1:0] cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink   (input valid, input sine, input cosine, output ready);
endinterface

FILE: sv/csc_fold.sv
// ----------------------------------------------------------------------------
// csc_fold
// Entry stage: folds the angle into [-pi/2, pi/2] and loads the start vector.
// ----------------------------------------------------------------------------
module csc_fold #(
  parameter int ANGLE_WIDTH  = csc_pkg::ANGLE_WIDTH_DEFAULT,
  parameter int RESULT_WIDTH = csc_pkg::RESULT_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  input  logic signed [ANGLE_WIDTH-1:0]  up_angle,
  output logic                           up_ready,
  output csc_pkg::ctrl_t                 dn_ctrl,
  output logic signed [RESULT_WIDTH-1:0] dn_x,
  output logic signed [RESULT_WIDTH-1:0] dn_y,
  output logic signed [ANGLE_WIDTH-1:0]  dn_z,
  input  logic                           dn_ready
);

  localparam logic signed [ANGLE_WIDTH-1:0] PI =
    ANGLE_WIDTH'(csc_pkg::rescale(csc_pkg::PI_Q30, ANGLE_WIDTH - 3));
  localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI = PI >>> 1;
  localparam logic signed [RESULT_WIDTH-1:0] GAIN =
    RESULT_WIDTH'(csc_pkg::rescale(csc_pkg::GAIN_Q30, RESULT_WIDTH - 2));

  logic signed [ANGLE_WIDTH-1:0] z_next;
  logic                          folded_next;

  always_comb begin
    priority if (up_angle > HALF_PI) begin
      z_next      = PI - up_angle;
      folded_next = 1'b1;
    end else if (up_angle < -HALF_PI) begin
      z_next      = -PI - up_angle;
      folded_next = 1'b1;
    end else begin
      z_next      = up_angle;
      folded_next = 1'b0;
    end
  end

  assign up_ready = !dn_ctrl.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctrl <= '0;
    end else if (up_ready) begin
      dn_ctrl.valid  <= up_valid;
      dn_ctrl.folded <= folded_next;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_x <= GAIN;
      dn_y <= '0;
      dn_z <= z_next;
    end
  end

endmodule

FILE: sv/csc_cell.sv
// ----------------------------------------------------------------------------
// csc_cell
// One CORDIC rotation step with its own vector register and handshake slot.
// ----------------------------------------------------------------------------
module csc_cell #(
  parameter int STAGE        = 0,
  parameter int ANGLE_WIDTH  = csc_pkg::ANGLE_WIDTH_DEFAULT,
  parameter int RESULT_WIDTH = csc_pkg::RESULT_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  csc_pkg::ctrl_t                 up_ctrl,
  input  logic signed [RESULT_WIDTH-1:0] up_x,
  input  logic signed [RESULT_WIDTH-1:0] up_y,
  input  logic signed [ANGLE_WIDTH-1:0]  up_z,
  output logic                           up_ready,
  output csc_pkg::ctrl_t                 dn_ctrl,
  output logic signed [RESULT_WIDTH-1:0] dn_x,
  output logic signed [RESULT_WIDTH-1:0] dn_y,
  output logic signed [ANGLE_WIDTH-1:0]  dn_z,
  input  logic                           dn_ready
);

  localparam logic signed [ANGLE_WIDTH-1:0] STEP_ANGLE =
    ANGLE_WIDTH'(csc_pkg::rescale(csc_pkg::ATAN_Q30[STAGE], ANGLE_WIDTH - 3));

  logic signed [RESULT_WIDTH-1:0] dx;
  logic signed [RESULT_WIDTH-1:0] dy;
  logic signed [RESULT_WIDTH-1:0] x_next;
  logic signed [RESULT_WIDTH-1:0] y_next;
  logic signed [ANGLE_WIDTH-1:0]  z_next;

  assign dx = up_y >>> STAGE;
  assign dy = up_x >>> STAGE;

  // A non-negative residual angle rotates anticlockwise.
  always_comb begin
    if (!up_z[ANGLE_WIDTH-1]) begin
      x_next = up_x - dx;
      y_next = up_y + dy;
      z_next = up_z - STEP_ANGLE;
    end else begin
      x_next = up_x + dx;
      y_next = up_y - dy;
      z_next = up_z + STEP_ANGLE;
    end
  end

  assign up_ready = !dn_ctrl.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctrl <= '0;
    end else if (up_ready) begin
      dn_ctrl <= up_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctrl.valid) begin
      dn_x <= x_next;
      dn_y <= y_next;
      dn_z <= z_next;
    end
  end

endmodule

FILE: sv/cordic_sine_cosine_top.sv
// ----------------------------------------------------------------------------
// cordic_sine_cosine_top
// Pipelined rotation-mode CORDIC giving the sine and cosine of an angle.
// ----------------------------------------------------------------------------
// Each angle beat (radians, two's complement with ANGLE_WIDTH-3 fraction
// bits) yields one result beat carrying its sine and cosine (two's complement
// with RESULT_WIDTH-2 fraction bits), in the order the angles arrived. The
// unit takes one angle per clock cycle for as long as results are taken. An
// accepted angle loads the folding stage at the edge that accepts it, then
// passes through each of the ITERATIONS rotation cells and finally the output
// register. Every stage has its own valid bit and moves whenever the stage
// after it is empty or moving, so a stalled result beat does not stop angles
// entering while any stage further up is empty; the pipeline holds ITERATIONS+2
// beats before it refuses new angles. The unit keeps no state between angles
// and needs no settling time after reset.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_top #(
  parameter int ITERATIONS   = csc_pkg::ITERATIONS_DEFAULT,
  parameter int ANGLE_WIDTH  = csc_pkg::ANGLE_WIDTH_DEFAULT,
  parameter int RESULT_WIDTH = csc_pkg::RESULT_WIDTH_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  csc_angle_if.sink    angles,
  csc_result_if.source results
);

  // Slot k of these arrays is the register bank feeding cell k; slot
  // ITERATIONS holds the vector after the final rotation.
  csc_pkg::ctrl_t                 ctrl  [ITERATIONS+1];
  logic signed [RESULT_WIDTH-1:0] x     [ITERATIONS+1];
  logic signed [RESULT_WIDTH-1:0] y     [ITERATIONS+1];
  logic signed [ANGLE_WIDTH-1:0]  z     [ITERATIONS+1];
  logic                           ready [ITERATIONS+1];

  // Folding stage: brings the angle into the convergence range of the
  // rotations and loads the gain-compensated start vector.
  csc_fold #(
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_fold (
    .clk      (clk),
    .rst      (rst),
    .up_valid (angles.valid),
    .up_angle (angles.angle),
    .up_ready (angles.ready),
    .dn_ctrl  (ctrl[0]),
    .dn_x     (x[0]),
    .dn_y     (y[0]),
    .dn_z     (z[0]),
    .dn_ready (ready[0])
  );

  // The chain of rotation cells, cell k shifting by k places.
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    csc_cell #(
      .STAGE        (k),
      .ANGLE_WIDTH  (ANGLE_WIDTH),
      .RESULT_WIDTH (RESULT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_ctrl  (ctrl[k]),
      .up_x     (x[k]),
      .up_y     (y[k]),
      .up_z     (z[k]),
      .up_ready (ready[k]),
      .dn_ctrl  (ctrl[k+1]),
      .dn_x     (x[k+1]),
      .dn_y     (y[k+1]),
      .dn_z     (z[k+1]),
      .dn_ready (ready[k+1])
    );
  end

  // The residual angle after the final rotation is not needed.
  logic signed [ANGLE_WIDTH-1:0] z_spent;
  assign z_spent = z[ITERATIONS];

  // Output register. The cosine of a folded angle lies in the other half
  // plane, so it is negated here; the sine is unaffected by the fold.
  assign ready[ITERATIONS] = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (ready[ITERATIONS]) begin
      results.valid <= ctrl[ITERATIONS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[ITERATIONS] && ctrl[ITERATIONS].valid) begin
      results.sine   <= y[ITERATIONS];
      results.cosine <= ctrl[ITERATIONS].folded ? -x[ITERATIONS] : x[ITERATIONS];
    end
  end

endmodule
